// ----- src/pvs_pkg.sv -----
// Package for the prediction vote smoother: widths, types, codes and the
// argmax helper. No dependencies.
package pvs_pkg;

  localparam int VOTE_DEPTH = 9;
  localparam int NUM_VOTED  = 3;
  localparam int CNT_W      = $clog2(VOTE_DEPTH + 1);
  localparam int STEP_W     = (VOTE_DEPTH > 1) ? $clog2(VOTE_DEPTH) : 1;
  localparam int SUM_W      = CNT_W + 1;
  localparam int VMIN_W     = 4;
  localparam int HOLD_W     = 16;
  localparam int TICK_W     = 32;
  localparam int SCORE_W    = 16;
  localparam int CMP_W      = (CNT_W > VMIN_W) ? CNT_W : VMIN_W;

  typedef logic [1:0]       class_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam class_t CLASS_UNKNOWN = 2'd3;

  localparam logic REG_VOTE_MIN = 1'b0;
  localparam logic REG_HOLDOFF  = 1'b1;

  localparam logic [VMIN_W-1:0] VOTE_MIN_RST = 4'd4;
  localparam logic [HOLD_W-1:0] HOLDOFF_RST  = 16'd1500;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    cnt_t   lead_cnt;
    class_t lead_cls;
  } tally_t;

  typedef struct packed {
    logic clear;
    logic en;
  } tally_ctl_t;

  function automatic class_t argmax4(input logic [SCORE_W-1:0] s0,
                                     input logic [SCORE_W-1:0] s1,
                                     input logic [SCORE_W-1:0] s2,
                                     input logic [SCORE_W-1:0] s3);
    logic [SCORE_W-1:0] top01;
    logic [SCORE_W-1:0] top23;
    class_t             c01;
    class_t             c23;
    c01   = (s1 > s0) ? 2'd1 : 2'd0;
    top01 = (s1 > s0) ? s1 : s0;
    c23   = (s3 > s2) ? 2'd3 : 2'd2;
    top23 = (s3 > s2) ? s3 : s2;
    return (top23 > top01) ? c23 : c01;
  endfunction

endpackage

// ----- src/pvs_cell.sv -----
// One cell of the prediction chain: holds one class and passes it on.
// Depends on pvs_pkg.
module pvs_cell
  import pvs_pkg::*;
(
  input  logic   clk,
  input  logic   shift_en,
  input  class_t cls_in,
  output class_t cls_out
);

  class_t cls_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      cls_r <= cls_in;
    end
  end

  assign cls_out = cls_r;

endmodule

// ----- src/pvs_tally.sv -----
// Vote counters for the voted classes and the winner pick.
// Depends on pvs_pkg.
module pvs_tally
  import pvs_pkg::*;
(
  input  logic       clk,
  input  tally_ctl_t ctl,
  input  class_t     cls,
  output tally_t     result
);

  cnt_t counts_r [NUM_VOTED];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      for (int i = 0; i < NUM_VOTED; i++) begin
        counts_r[i] <= '0;
      end
    end else if (ctl.en && cls != CLASS_UNKNOWN) begin
      counts_r[cls] <= counts_r[cls] + cnt_t'(1);
    end
  end

  always_comb begin
    result.lead_cnt = '0;
    result.lead_cls = '0;
    for (int i = 0; i < NUM_VOTED; i++) begin
      if (counts_r[i] > result.lead_cnt) begin
        result.lead_cnt = counts_r[i];
        result.lead_cls = class_t'(i);
      end
    end
  end

endmodule

// ----- src/prediction_vote_smoother.sv -----
// Top level of the prediction vote smoother: chain of pvs_cell, pvs_tally
// and the control sequencer. Depends on pvs_pkg, pvs_cell and pvs_tally.
//
//   port group  direction  handshake           payload
//   in_*        input      in_valid/in_ready   four scores, now_ticks
//   out_*       output     out_valid/out_ready class, stable, voted, announce
//   cfg_*       input      cfg_we              cfg_index, cfg_wdata
//
// A word is handled in order: the new class is shifted into the chain, the
// chain is rotated once past the vote counters, and then the decision is
// made; no new word is accepted until then. Reset clears control state and
// loads the configuration registers with their reset values.
// A finished result waits in the output register; the next word may be
// accepted meanwhile, and its decision stalls until the register is free.
module prediction_vote_smoother
  import pvs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SCORE_W-1:0]  in_score_a,
  input  logic [SCORE_W-1:0]  in_score_b,
  input  logic [SCORE_W-1:0]  in_score_c,
  input  logic [SCORE_W-1:0]  in_score_d,
  input  logic [TICK_W-1:0]   in_now_ticks,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_predicted_class,
  output logic                out_stable,
  output logic [1:0]          out_voted_class,
  output logic                out_announce,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [HOLD_W-1:0]   cfg_wdata
);

  state_t              state_r, state_nxt;
  logic [VMIN_W-1:0]   vote_min_r;
  logic [HOLD_W-1:0]   holdoff_r;
  cnt_t                fill_r;
  logic [STEP_W-1:0]   step_r;
  class_t              pred_r;
  logic [TICK_W-1:0]   now_r;
  class_t              last_class_r;
  logic                last_valid_r;
  logic [TICK_W-1:0]   last_time_r;
  logic                out_valid_r;
  class_t              out_pred_r;
  logic                out_stable_r;
  class_t              out_voted_r;
  logic                out_announce_r;

  logic                accept;
  logic                shift_en;
  logic                rotate;
  logic                decide_fire;
  logic                last_step;
  logic [SUM_W-1:0]    step_sum;
  class_t              pred_in;
  class_t              chain [VOTE_DEPTH];
  class_t              head_in;
  tally_ctl_t          tctl;
  tally_t              tres;
  logic                stable;
  logic                announce;
  logic [TICK_W-1:0]   elapsed;

  assign pred_in   = argmax4(in_score_a, in_score_b, in_score_c, in_score_d);
  assign accept    = in_valid && in_ready;
  assign last_step = (step_r == STEP_W'(VOTE_DEPTH - 1));
  assign step_sum  = SUM_W'(step_r) + SUM_W'(fill_r);
  assign head_in   = rotate ? chain[VOTE_DEPTH-1] : pred_in;

  for (genvar g = 0; g < VOTE_DEPTH; g++) begin : g_cell
    class_t cell_in;
    if (g == 0) begin : g_head
      assign cell_in = head_in;
    end else begin : g_body
      assign cell_in = chain[g-1];
    end
    pvs_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .cls_in   (cell_in),
      .cls_out  (chain[g])
    );
  end

  pvs_tally u_tally (
    .clk    (clk),
    .ctl    (tctl),
    .cls    (chain[VOTE_DEPTH-1]),
    .result (tres)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_COUNT;
      ST_COUNT:  if (last_step) state_nxt = ST_DECIDE;
      ST_DECIDE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    rotate      = 1'b0;
    decide_fire = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_COUNT:  rotate = 1'b1;
      ST_DECIDE: decide_fire = !out_valid_r || out_ready;
      default:   in_ready = 1'b0;
    endcase
    shift_en   = accept || rotate;
    tctl.clear = accept;
    tctl.en    = rotate && (step_sum >= SUM_W'(VOTE_DEPTH));
  end

  assign elapsed  = now_r - last_time_r;
  assign stable   = (tres.lead_cnt != '0) &&
                    (CMP_W'(tres.lead_cnt) >= CMP_W'(vote_min_r));
  assign announce = stable && (!last_valid_r || tres.lead_cls != last_class_r ||
                    elapsed > TICK_W'(holdoff_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      vote_min_r   <= VOTE_MIN_RST;
      holdoff_r    <= HOLDOFF_RST;
      fill_r       <= '0;
      step_r       <= '0;
      last_class_r <= '0;
      last_valid_r <= 1'b0;
      last_time_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_VOTE_MIN: vote_min_r <= cfg_wdata[VMIN_W-1:0];
          REG_HOLDOFF:  holdoff_r  <= cfg_wdata;
          default:      holdoff_r  <= holdoff_r;
        endcase
      end
      if (accept) begin
        step_r <= '0;
        if (fill_r != cnt_t'(VOTE_DEPTH)) begin
          fill_r <= fill_r + cnt_t'(1);
        end
      end else if (rotate && !last_step) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (decide_fire && announce) begin
        last_class_r <= tres.lead_cls;
        last_valid_r <= 1'b1;
        last_time_r  <= now_r;
      end
      if (decide_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pred_r <= pred_in;
      now_r  <= in_now_ticks;
    end
    if (decide_fire) begin
      out_pred_r     <= pred_r;
      out_stable_r   <= stable;
      out_voted_r    <= stable ? tres.lead_cls : class_t'(0);
      out_announce_r <= announce;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_pred_r;
  assign out_stable          = out_stable_r;
  assign out_voted_class     = out_voted_r;
  assign out_announce        = out_announce_r;

endmodule

// ----- tb/tb_prediction_vote_smoother.sv -----
// Self-checking testbench for prediction_vote_smoother: directed and random words,
// checked against an in-bench vote predictor.
// Depends on pvs_pkg and the prediction_vote_smoother RTL.
module tb_prediction_vote_smoother;
  timeunit 1ns;
  timeprecision 1ps;
  import pvs_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SWEEP_PHASES  = 16;
  localparam int unsigned PHASE_WORDS   = 125;

  typedef logic [3:0][SCORE_W-1:0] score_set_t;

  typedef struct packed {
    class_t predicted;
    logic   stable;
    class_t voted;
    logic   announce;
  } vote_word_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [SCORE_W-1:0] in_score_a;
  logic [SCORE_W-1:0] in_score_b;
  logic [SCORE_W-1:0] in_score_c;
  logic [SCORE_W-1:0] in_score_d;
  logic [TICK_W-1:0]  in_now_ticks;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_predicted_class;
  logic               out_stable;
  logic [1:0]         out_voted_class;
  logic               out_announce;
  logic               cfg_we;
  logic               cfg_index;
  logic [HOLD_W-1:0]  cfg_wdata;

  // predictor state and its copy of the registers
  class_t             tally_ring [VOTE_DEPTH];
  int unsigned        ring_wr;
  int unsigned        ring_count;
  class_t             last_cls;
  logic               last_cls_valid;
  logic [TICK_W-1:0]  last_stamp;
  logic [VMIN_W-1:0]  vote_min_r;
  logic [HOLD_W-1:0]  holdoff_r;

  vote_word_t         pending_votes[$];
  int unsigned        errors;
  int unsigned        words_out;
  int unsigned        stable_seen;
  int unsigned        announce_seen;
  int unsigned        settings_written;
  int unsigned        long_holds;
  int unsigned        tx_max_gap;
  int unsigned        rx_max_gap;
  logic               hold_req;
  logic [TICK_W-1:0]  tick_now;

  prediction_vote_smoother DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_score_a          (in_score_a),
    .in_score_b          (in_score_b),
    .in_score_c          (in_score_c),
    .in_score_d          (in_score_d),
    .in_now_ticks        (in_now_ticks),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_predicted_class (out_predicted_class),
    .out_stable          (out_stable),
    .out_voted_class     (out_voted_class),
    .out_announce        (out_announce),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic class_t argmax_of(score_set_t s);
    class_t             best;
    logic [SCORE_W-1:0] top;
    best = 2'd0;
    top  = s[0];
    for (int i = 1; i < 4; i++) begin
      if (s[i] > top) begin
        top  = s[i];
        best = class_t'(i);
      end
    end
    return best;
  endfunction

  task automatic predict_vote(input score_set_t s, input logic [TICK_W-1:0] now,
                              output vote_word_t w);
    int unsigned       votes [NUM_VOTED];
    int unsigned       top_votes;
    class_t            best;
    class_t            pred;
    logic              stable;
    logic [TICK_W-1:0] elapsed;
    pred = argmax_of(s);
    tally_ring[ring_wr] = pred;
    ring_wr = (ring_wr == VOTE_DEPTH - 1) ? 0 : ring_wr + 1;
    if (ring_count < VOTE_DEPTH) ring_count++;
    for (int i = 0; i < NUM_VOTED; i++) votes[i] = 0;
    for (int i = 0; i < ring_count; i++) begin
      if (tally_ring[i] != CLASS_UNKNOWN) votes[tally_ring[i]]++;
    end
    top_votes = 0;
    best      = 2'd0;
    for (int i = 0; i < NUM_VOTED; i++) begin
      if (votes[i] > top_votes) begin
        top_votes = votes[i];
        best      = class_t'(i);
      end
    end
    stable = (top_votes > 0) && (top_votes >= vote_min_r);
    if (!stable) best = 2'd0;
    elapsed    = now - last_stamp;
    w.predicted = pred;
    w.stable    = stable;
    w.voted     = best;
    w.announce  = 1'b0;
    if (stable && (!last_cls_valid || best != last_cls || elapsed > holdoff_r)) begin
      w.announce     = 1'b1;
      last_cls       = best;
      last_cls_valid = 1'b1;
      last_stamp     = now;
    end
  endtask

  function automatic void check_field(string name, logic [1:0] want, logic [1:0] seen);
    if (want !== seen) begin
      errors++;
      if (errors <= 10)
        $display("mismatch on word %0d: %s expected %0d, got %0d", words_out, name, want, seen);
    end
  endfunction

  always @(posedge clk) begin
    vote_word_t want_w;
    vote_word_t got_w;
    if (!rst_n) begin
      ring_wr        = 0;
      ring_count     = 0;
      last_cls       = 2'd0;
      last_cls_valid = 1'b0;
      last_stamp     = '0;
      vote_min_r     = VOTE_MIN_RST;
      holdoff_r      = HOLDOFF_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_VOTE_MIN: vote_min_r = cfg_wdata[VMIN_W-1:0];
          REG_HOLDOFF:  holdoff_r  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_vote({in_score_d, in_score_c, in_score_b, in_score_a}, in_now_ticks, want_w);
        pending_votes.push_back(want_w);
      end
      if (out_valid && out_ready) begin
        got_w = '{out_predicted_class, out_stable, out_voted_class, out_announce};
        if (pending_votes.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %0d: %p", words_out, got_w);
        end else begin
          want_w = pending_votes.pop_front();
          check_field("predicted_class", want_w.predicted, got_w.predicted);
          check_field("stable", {1'b0, want_w.stable}, {1'b0, got_w.stable});
          check_field("voted_class", want_w.voted, got_w.voted);
          check_field("announce", {1'b0, want_w.announce}, {1'b0, got_w.announce});
          if (want_w.stable) stable_seen++;
          if (want_w.announce) announce_seen++;
        end
        words_out++;
      end
    end
  end

  // result side: random stall per word, long hold when asked
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        stall    = LONG_HOLD;
        hold_req = 1'b0;
        long_holds++;
      end else begin
        stall = $urandom_range(0, rx_max_gap);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
      @(negedge clk);
    end
  end

  task automatic send_word(input score_set_t s, input logic [TICK_W-1:0] now);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_score_a   <= s[0];
    in_score_b   <= s[1];
    in_score_c   <= s[2];
    in_score_d   <= s[3];
    in_now_ticks <= now;
    in_valid     <= 1'b1;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_votes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [HOLD_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [VMIN_W-1:0] vmin, input logic [HOLD_W-1:0] hold);
    logic [HOLD_W-VMIN_W-1:0] junk;
    junk = (HOLD_W-VMIN_W)'($urandom);
    drain();
    write_reg(REG_VOTE_MIN, {junk, vmin});
    write_reg(REG_HOLDOFF, hold);
    settings_written++;
  endtask

  function automatic score_set_t one_hot(class_t cls, logic [SCORE_W-1:0] val);
    score_set_t s;
    s      = '0;
    s[cls] = val;
    return s;
  endfunction

  function automatic score_set_t make_scores(class_t cls);
    score_set_t         s;
    int unsigned        pick;
    logic [SCORE_W-1:0] top;
    pick = $urandom_range(0, 15);
    top  = SCORE_W'($urandom_range(1, 16'hFFFF));
    for (int i = 0; i < 4; i++) s[i] = SCORE_W'($urandom_range(0, top - 1));
    s[cls] = top;
    if (pick == 0) begin
      for (int i = 0; i < 4; i++) s[i] = SCORE_W'($urandom);
    end else if (pick == 1) begin
      s[$urandom_range(0, 3)] = top;
    end else if (pick == 2) begin
      s[$urandom_range(0, 3)] = 16'hFFFF;
    end
    return s;
  endfunction

  task automatic test_defaults_directed();
    score_set_t s;
    send_word('0, 32'd0);
    send_word({4{16'hFFFF}}, 32'd0);
    s = '0; s[1] = 16'hFFFF; s[2] = 16'hFFFF;
    send_word(s, 32'd0);
    s = '0; s[2] = 16'hFFFF; s[3] = 16'hFFFF;
    send_word(s, 32'd0);
    send_word(one_hot(CLASS_UNKNOWN, 16'hFFFF), 32'd0);
    send_word(one_hot(2'd0, 16'h0001), 32'd0);
    repeat (4) send_word(one_hot(2'd1, 16'hFFFF), 32'd1000);
    send_word(one_hot(2'd1, 16'h8000), 32'd2500);
    send_word(one_hot(2'd1, 16'h7FFF), 32'd2501);
    send_word(one_hot(2'd1, 16'hFFFF), 32'hFFFF_FF00);
    send_word(one_hot(2'd1, 16'hFFFF), 32'h0000_0100);
    send_word(one_hot(2'd1, 16'hFFFF), 32'h0000_04DD);
    repeat (5) send_word(one_hot(2'd2, 16'hFFFF), 32'h0000_04DE);
    send_word('0, 32'hFFFF_FFFF);
    tick_now = 32'hFFFF_FFFF;
  endtask

  task automatic test_unknown_votes();
    configure(4'd0, 16'd0);
    repeat (VOTE_DEPTH) begin
      tick_now = tick_now + 1;
      send_word(one_hot(CLASS_UNKNOWN, SCORE_W'($urandom_range(1, 16'hFFFF))), tick_now);
    end
    tick_now = tick_now + 1;
    send_word('0, tick_now);
  endtask

  task automatic test_vote_min_limits();
    configure(4'd12, 16'hFFFF);
    repeat (2) send_word(one_hot(2'd0, 16'hFFFF), tick_now);
    configure(4'd1, 16'd0);
    send_word(one_hot(2'd2, 16'hFFFF), tick_now);
    send_word(one_hot(2'd2, 16'hFFFF), tick_now);
    tick_now = tick_now + 1;
    send_word(one_hot(2'd2, 16'hFFFF), tick_now);
  endtask

  task automatic test_random_sweep();
    logic [VMIN_W-1:0] vmin;
    logic [HOLD_W-1:0] hold;
    class_t            run_cls;
    int unsigned       run_left;
    int unsigned       step;
    run_left = 0;
    run_cls  = 2'd0;
    for (int p = 0; p < SWEEP_PHASES; p++) begin
      case (p % 5)
        0: vmin = 4'd1;
        1: vmin = 4'd9;
        2: vmin = VMIN_W'($urandom_range(0, 15));
        default: vmin = VMIN_W'($urandom_range(2, 8));
      endcase
      case (p % 3)
        0: hold = 16'd0;
        1: hold = 16'hFFFF;
        default: hold = HOLD_W'($urandom_range(1, 3000));
      endcase
      configure(vmin, hold);
      case (p % 4)
        3: begin tx_max_gap = 0; rx_max_gap = 0; end
        2: begin tx_max_gap = 0; rx_max_gap = 9; end
        1: begin tx_max_gap = 9; rx_max_gap = 0; end
        default: begin tx_max_gap = 9; rx_max_gap = 9; end
      endcase
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (run_left == 0) begin
          run_cls  = ($urandom_range(0, 7) == 0) ? CLASS_UNKNOWN : class_t'($urandom_range(0, 2));
          run_left = $urandom_range(1, 14);
        end
        run_left--;
        if ($urandom_range(0, 31) == 0) step = $urandom;
        else step = $urandom_range(0, 2 * hold + 64);
        tick_now = tick_now + step;
        send_word(make_scores(run_cls), tick_now);
      end
    end
    tx_max_gap = 9;
    rx_max_gap = 9;
  endtask

  task automatic test_backpressure();
    drain();
    hold_req   = 1'b1;
    tx_max_gap = 0;
    repeat (40) begin
      tick_now = tick_now + $urandom_range(0, 200);
      send_word(make_scores(class_t'($urandom_range(0, 3))), tick_now);
    end
    tx_max_gap = 9;
  endtask

  task automatic test_drain_pause();
    repeat (5) begin
      repeat (8) begin
        tick_now = tick_now + $urandom_range(0, 2000);
        send_word(make_scores(class_t'($urandom_range(0, 2))), tick_now);
      end
      drain();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_score_a   = '0;
    in_score_b   = '0;
    in_score_c   = '0;
    in_score_d   = '0;
    in_now_ticks = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_VOTE_MIN;
    cfg_wdata    = '0;
    hold_req     = 1'b0;
    tx_max_gap   = 9;
    rx_max_gap   = 9;
    tick_now     = '0;
    errors       = 0;
    words_out    = 0;
    stable_seen  = 0;
    announce_seen    = 0;
    settings_written = 0;
    long_holds       = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_defaults_directed();
    test_unknown_votes();
    test_vote_min_limits();
    test_random_sweep();
    test_backpressure();
    test_drain_pause();

    drain();
    if (pending_votes.size() != 0) errors += pending_votes.size();
    $display("covered %0d words over %0d register settings: %0d stable, %0d announced",
             words_out, settings_written, stable_seen, announce_seen);
    $display("random idle and stall gaps per word, %0d long output hold-offs, %0d errors",
             long_holds, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d words still pending", pending_votes.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
src/pvs_pkg.sv
src/pvs_cell.sv
src/pvs_tally.sv
src/prediction_vote_smoother.sv
tb/tb_prediction_vote_smoother.sv
